// File: sv/pkc_pkg.sv
// Shared types and constants for the power-key long-press controller.
// No dependencies; every other file in sv/ refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package pkc_pkg;

    localparam int unsigned TimeW     = 32;
    localparam int unsigned HoldW     = 16;
    localparam int unsigned WindowW   = 16;
    localparam int unsigned DebounceW = 8;
    localparam int unsigned CauseW    = 2;
    localparam int unsigned CfgIdxW   = 2;
    localparam int unsigned CfgDataW  = 16;
    localparam int unsigned InDataW   = 40;
    localparam int unsigned OutDataW  = 8;

    localparam logic [HoldW-1:0]     HoldReset     = 16'd2000;
    localparam logic [WindowW-1:0]   WindowReset   = 16'd0;
    localparam logic [DebounceW-1:0] DebounceReset = 8'd30;

    typedef enum logic [CfgIdxW-1:0] {
        REG_HOLD_TO_SLEEP = 2'd0,
        REG_WAKE_WINDOW   = 2'd1,
        REG_DEBOUNCE      = 2'd2,
        REG_BOOT_CAUSE    = 2'd3
    } t_cfg_idx;

    typedef enum logic [CauseW-1:0] {
        CAUSE_OTHER_RESET = 2'd0,
        CAUSE_GPIO_WAKE   = 2'd1,
        CAUSE_OTHER_WAKE  = 2'd2,
        CAUSE_POWER_ON    = 2'd3
    } t_boot_cause;

    typedef enum logic [2:0] {
        PH_VERIFY       = 3'd0,
        PH_WAIT_RELEASE = 3'd1,
        PH_MONITOR      = 3'd2,
        PH_SLEEP_WAIT   = 3'd3,
        PH_ASLEEP       = 3'd4
    } t_phase;

    typedef struct packed {
        logic [HoldW-1:0]     hold_to_sleep_ms;
        logic [WindowW-1:0]   wake_window_ms;
        logic [DebounceW-1:0] debounce_ms;
        t_boot_cause          boot_cause;
    } t_cfg;

    typedef struct packed {
        logic [TimeW-1:0] now_ms;
        logic             button_pressed;
        logic             usb_present;
    } t_sample;

    typedef struct packed {
        t_phase           phase;
        logic             window_started;
        logic [TimeW-1:0] window_start_ms;
        logic             debounced;
        logic [TimeW-1:0] last_change_ms;
        logic [TimeW-1:0] press_start_ms;
        logic             latch;
    } t_state;

    typedef struct packed {
        t_phase phase_code;
        logic   debounced_level;
        logic   sleep_request;
        logic   latch_on;
    } t_result;

endpackage

`default_nettype wire

// File: sv/power_key_long_press_controller_top.sv
// Top level of the power-key long-press controller: input register, controller
// state, result register and stream handshakes. Uses pkc_pkg, pkc_cfg_regs, pkc_step.
//
//  Channel   Dir  Handshake                  Payload
//  --------  ---  -------------------------  ------------------------------------------
//  sample    in   i_s_tvalid / o_s_tready    i_s_tdata: now_ms, button_pressed, usb_present
//  result    out  o_m_tvalid / i_m_tready    o_m_tdata: latch_on, sleep_request,
//                                            debounced_level, phase_code
//  config    in   i_cfg_we (always taken)    i_cfg_idx, i_cfg_data
//
// One sample is accepted per cycle while o_s_tready is high; each gives exactly one result
// after passing the input register, then the result register. The only loop is the
// controller state, which the combinational step logic updates once per sample.
// Reset (synchronous, active low) puts the controller in boot verification with
// the latch driven on and both pipeline stages empty.
// A stalled output holds the result register; the input register still refills
// while the result waits, and o_s_tready drops only when both stages are full.
`timescale 1ns / 1ps
`default_nettype none

module power_key_long_press_controller_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // sample stream
    input  wire logic                           i_s_tvalid,
    output wire logic                           o_s_tready,
    // [31:0] now_ms, [32] button_pressed, [33] usb_present, [39:34] zero
    input  wire logic [pkc_pkg::InDataW-1:0]    i_s_tdata,
    // result stream
    output wire logic                           o_m_tvalid,
    input  wire logic                           i_m_tready,
    // [0] latch_on, [1] sleep_request, [2] debounced_level, [5:3] phase_code,
    // [7:6] zero
    output wire logic [pkc_pkg::OutDataW-1:0]   o_m_tdata,
    // configuration writes
    input  wire logic                           i_cfg_we,
    input  wire logic [pkc_pkg::CfgIdxW-1:0]    i_cfg_idx,
    input  wire logic [pkc_pkg::CfgDataW-1:0]   i_cfg_data
);

    pkc_pkg::t_cfg    cfg;
    pkc_pkg::t_state  n_state;
    pkc_pkg::t_result n_result;

    logic             r_s1_valid;
    pkc_pkg::t_sample r_s1_sample;
    pkc_pkg::t_state  r_state;
    logic             r_m_valid;
    pkc_pkg::t_result r_m_result;

    logic s1_advance;
    logic s_transfer;

    // result register frees up when empty or when its contents go out this cycle
    assign s1_advance = r_s1_valid && (!r_m_valid || i_m_tready);
    assign o_s_tready = !r_s1_valid || s1_advance;
    assign s_transfer = i_s_tvalid && o_s_tready;

    pkc_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    pkc_step u_step (
        .i_cfg    (cfg),
        .i_state  (r_state),
        .i_sample (r_s1_sample),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_transfer) begin
            r_s1_valid <= 1'b1;
        end else if (s1_advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_transfer) begin
            r_s1_sample.now_ms         <= i_s_tdata[pkc_pkg::TimeW-1:0];
            r_s1_sample.button_pressed <= i_s_tdata[pkc_pkg::TimeW];
            r_s1_sample.usb_present    <= i_s_tdata[pkc_pkg::TimeW+1];
        end
    end

    // controller state, updated once per sample leaving the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase           <= pkc_pkg::PH_VERIFY;
            r_state.window_started  <= 1'b0;
            r_state.window_start_ms <= '0;
            r_state.debounced       <= 1'b0;
            r_state.last_change_ms  <= '0;
            r_state.press_start_ms  <= '0;
            r_state.latch           <= 1'b1;
        end else if (s1_advance) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (s1_advance) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance) begin
            r_m_result <= n_result;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {2'b00, r_m_result.phase_code, r_m_result.debounced_level,
                         r_m_result.sleep_request, r_m_result.latch_on};

endmodule

`default_nettype wire

// File: sv/pkc_cfg_regs.sv
// Configuration register file: four write-only registers with reset values.
// Depends on pkc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pkc_cfg_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [pkc_pkg::CfgIdxW-1:0]   i_cfg_idx,
    input  wire logic [pkc_pkg::CfgDataW-1:0]  i_cfg_data,
    output pkc_pkg::t_cfg                      o_cfg
);

    pkc_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hold_to_sleep_ms <= pkc_pkg::HoldReset;
            r_cfg.wake_window_ms   <= pkc_pkg::WindowReset;
            r_cfg.debounce_ms      <= pkc_pkg::DebounceReset;
            r_cfg.boot_cause       <= pkc_pkg::CAUSE_OTHER_RESET;
        end else if (i_cfg_we) begin
            unique case (pkc_pkg::t_cfg_idx'(i_cfg_idx))
                pkc_pkg::REG_HOLD_TO_SLEEP: begin
                    r_cfg.hold_to_sleep_ms <= i_cfg_data;
                end
                pkc_pkg::REG_WAKE_WINDOW: begin
                    r_cfg.wake_window_ms <= i_cfg_data;
                end
                pkc_pkg::REG_DEBOUNCE: begin
                    r_cfg.debounce_ms <= i_cfg_data[pkc_pkg::DebounceW-1:0];
                end
                pkc_pkg::REG_BOOT_CAUSE: begin
                    r_cfg.boot_cause <= pkc_pkg::t_boot_cause'(i_cfg_data[pkc_pkg::CauseW-1:0]);
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: sv/pkc_step.sv
// Next-state and result logic for one poll sample: boot check, release wait,
// debounce, long-hold detection and sleep entry. Purely combinational; uses pkc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pkc_step (
    input  wire pkc_pkg::t_cfg    i_cfg,
    input  wire pkc_pkg::t_state  i_state,
    input  wire pkc_pkg::t_sample i_sample,
    output pkc_pkg::t_state       o_state,
    output pkc_pkg::t_result      o_result
);

    always_comb begin
        pkc_pkg::t_state            st;
        logic                       initiated;
        logic [pkc_pkg::TimeW-1:0]  win_age;
        logic [pkc_pkg::TimeW-1:0]  change_age;
        logic [pkc_pkg::TimeW-1:0]  hold_age;

        st = i_state;
        initiated = (i_cfg.boot_cause == pkc_pkg::CAUSE_GPIO_WAKE)
                 || ((i_cfg.boot_cause == pkc_pkg::CAUSE_POWER_ON) && !i_sample.usb_present);

        // boot verification; first sample opens the window and cannot time out
        if (st.phase == pkc_pkg::PH_VERIFY && !st.window_started) begin
            if (i_cfg.wake_window_ms == '0 || !initiated) begin
                st.phase = pkc_pkg::PH_WAIT_RELEASE;
            end else begin
                st.window_started  = 1'b1;
                st.window_start_ms = i_sample.now_ms;
            end
        end
        win_age = i_sample.now_ms - st.window_start_ms;
        if (st.phase == pkc_pkg::PH_VERIFY) begin
            if (i_sample.button_pressed) begin
                st.phase = pkc_pkg::PH_WAIT_RELEASE;
            end else if (win_age >= {{(pkc_pkg::TimeW-pkc_pkg::WindowW){1'b0}},
                                     i_cfg.wake_window_ms}) begin
                st.phase = pkc_pkg::PH_SLEEP_WAIT;
            end
        end

        if (st.phase == pkc_pkg::PH_WAIT_RELEASE && !i_sample.button_pressed) begin
            st.phase          = pkc_pkg::PH_MONITOR;
            st.debounced      = 1'b0;
            st.last_change_ms = '0;
            st.press_start_ms = '0;
        end

        change_age = i_sample.now_ms - st.last_change_ms;
        if (st.phase == pkc_pkg::PH_MONITOR) begin
            if (change_age >= {{(pkc_pkg::TimeW-pkc_pkg::DebounceW){1'b0}}, i_cfg.debounce_ms}
                && (i_sample.button_pressed != st.debounced)) begin
                st.last_change_ms = i_sample.now_ms;
                st.debounced      = i_sample.button_pressed;
                if (i_sample.button_pressed) begin
                    st.press_start_ms = i_sample.now_ms;
                end
            end
        end
        hold_age = i_sample.now_ms - st.press_start_ms;
        if (st.phase == pkc_pkg::PH_MONITOR && st.debounced && i_cfg.hold_to_sleep_ms != '0
            && hold_age >= {{(pkc_pkg::TimeW-pkc_pkg::HoldW){1'b0}}, i_cfg.hold_to_sleep_ms}) begin
            st.phase = pkc_pkg::PH_SLEEP_WAIT;
        end

        if (st.phase == pkc_pkg::PH_SLEEP_WAIT && !i_sample.button_pressed) begin
            st.latch = 1'b0;
            st.phase = pkc_pkg::PH_ASLEEP;
        end

        o_state                  = st;
        o_result.latch_on        = st.latch;
        o_result.sleep_request   = (st.phase == pkc_pkg::PH_ASLEEP);
        o_result.debounced_level = st.debounced;
        o_result.phase_code      = st.phase;
    end

endmodule

`default_nettype wire

// File: tb/pkc_status_board_pkg.sv
// Scoreboard for the power-key controller bench: predicts each result and checks it.
// Depends on pkc_pkg for register, phase and result types.
`timescale 1ns / 1ps

package pkc_tb_pkg;
    import pkc_pkg::*;

    class key_status_board;
        t_cfg    regs;
        t_state  ctl;
        t_result expected_status_q[$];
        int      errors;
        int      samples_seen;
        int      results_seen;

        function new();
            regs.hold_to_sleep_ms = HoldReset;
            regs.wake_window_ms   = WindowReset;
            regs.debounce_ms      = DebounceReset;
            regs.boot_cause       = CAUSE_OTHER_RESET;
            ctl.phase             = PH_VERIFY;
            ctl.window_started    = 1'b0;
            ctl.window_start_ms   = '0;
            ctl.debounced         = 1'b0;
            ctl.last_change_ms    = '0;
            ctl.press_start_ms    = '0;
            ctl.latch             = 1'b1;
            errors                = 0;
            samples_seen          = 0;
            results_seen          = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CfgDataW-1:0] value);
            case (idx)
                REG_HOLD_TO_SLEEP: regs.hold_to_sleep_ms = value[HoldW-1:0];
                REG_WAKE_WINDOW:   regs.wake_window_ms   = value[WindowW-1:0];
                REG_DEBOUNCE:      regs.debounce_ms      = value[DebounceW-1:0];
                REG_BOOT_CAUSE:    regs.boot_cause       = t_boot_cause'(value[CauseW-1:0]);
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_status_q.size();
        endfunction

        // advance the controller by one poll sample and queue the status it should report
        function void note_sample(t_sample s);
            logic             initiated;
            logic [TimeW-1:0] elapsed;
            t_result          r;

            if (ctl.phase == PH_VERIFY) begin
                if (!ctl.window_started) begin
                    initiated = (regs.boot_cause == CAUSE_GPIO_WAKE) ||
                                (regs.boot_cause == CAUSE_POWER_ON && !s.usb_present);
                    if (regs.wake_window_ms == '0 || !initiated) begin
                        ctl.phase = PH_WAIT_RELEASE;
                    end else begin
                        ctl.window_started  = 1'b1;
                        ctl.window_start_ms = s.now_ms;
                    end
                end
                if (ctl.phase == PH_VERIFY) begin
                    elapsed = s.now_ms - ctl.window_start_ms;
                    if (s.button_pressed) begin
                        ctl.phase = PH_WAIT_RELEASE;
                    end else if (elapsed >= regs.wake_window_ms) begin
                        ctl.phase = PH_SLEEP_WAIT;
                    end
                end
            end

            if (ctl.phase == PH_WAIT_RELEASE && !s.button_pressed) begin
                ctl.phase          = PH_MONITOR;
                ctl.debounced      = 1'b0;
                ctl.last_change_ms = '0;
                ctl.press_start_ms = '0;
            end

            if (ctl.phase == PH_MONITOR) begin
                elapsed = s.now_ms - ctl.last_change_ms;
                if (elapsed >= regs.debounce_ms && s.button_pressed != ctl.debounced) begin
                    ctl.last_change_ms = s.now_ms;
                    ctl.debounced      = s.button_pressed;
                    if (ctl.debounced)
                        ctl.press_start_ms = s.now_ms;
                end
                elapsed = s.now_ms - ctl.press_start_ms;
                if (ctl.debounced && regs.hold_to_sleep_ms != '0 &&
                    elapsed >= regs.hold_to_sleep_ms)
                    ctl.phase = PH_SLEEP_WAIT;
            end

            if (ctl.phase == PH_SLEEP_WAIT && !s.button_pressed) begin
                ctl.latch = 1'b0;
                ctl.phase = PH_ASLEEP;
            end

            r.latch_on        = ctl.latch;
            r.sleep_request   = (ctl.phase == PH_ASLEEP);
            r.debounced_level = ctl.debounced;
            r.phase_code      = ctl.phase;
            expected_status_q.push_back(r);
            samples_seen++;
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_status(logic [OutDataW-1:0] data);
            t_result want;

            results_seen++;
            if (expected_status_q.size() == 0) begin
                $error("result transfer with nothing outstanding: tdata %h", data);
                errors++;
                return;
            end
            want = expected_status_q.pop_front();
            compare_field("latch_on", 8'(want.latch_on), 8'(data[0]));
            compare_field("sleep_request", 8'(want.sleep_request), 8'(data[1]));
            compare_field("debounced_level", 8'(want.debounced_level), 8'(data[2]));
            compare_field("phase_code", 8'(want.phase_code), 8'(data[5:3]));
            compare_field("padding", 8'd0, 8'(data[7:6]));
        endfunction
    endclass

endpackage

// File: tb/power_key_long_press_controller_top_test.sv
// Bench for power_key_long_press_controller_top: drives poll samples and register
// writes, checks every result against key_status_board. Uses pkc_pkg and pkc_tb_pkg.
`timescale 1ns / 1ps

module power_key_long_press_controller_top_test;
    import pkc_pkg::*;
    import pkc_tb_pkg::*;

    localparam int IdleLimit = 2000;   // cycles with no transfer before giving up

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [InDataW-1:0]    s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OutDataW-1:0]   m_tdata;
    logic                  cfg_we   = 1'b0;
    logic [CfgIdxW-1:0]    cfg_idx  = '0;
    logic [CfgDataW-1:0]   cfg_data = '0;

    key_status_board board = new();
    logic [TimeW-1:0] clock_ms = '0;   // current poll time stamp
    int               reg_writes = 0;
    bit               gaps_off = 1'b0;
    int               quiet = 0;

    power_key_long_press_controller_top uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // sender idle length: mostly none, some short, a few long
    function automatic int gap_len();
        int r;
        r = $urandom_range(99, 0);
        if (gaps_off || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(3, 1);
        return $urandom_range(20, 5);
    endfunction

    // one sample transfer; inputs move on the falling edge, acceptance seen on the rising one
    task automatic send_sample(logic [TimeW-1:0] now, logic pressed, logic usb);
        t_sample s;
        int      gap;

        s.now_ms         = now;
        s.button_pressed = pressed;
        s.usb_present    = usb;
        gap              = gap_len();
        @(negedge clk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, usb, pressed, now};
        do @(posedge clk); while (!s_tready);
        board.note_sample(s);
        clock_ms = now;
    endtask

    // advance time by a random step and send
    task automatic step_sample(int step_max, logic pressed);
        send_sample(clock_ms + $urandom_range(step_max, 1), pressed, 1'($urandom));
    endtask

    // hold the sender back until every outstanding result has come out
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CfgDataW-1:0] value);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        board.write_reg(idx, value);
        reg_writes++;
    endtask

    // a realistic press: contact bounce in, a hold, bounce out, then a released spell
    // with the odd glitch
    task automatic press_sequence(int hold_ms, int step_max);
        logic [TimeW-1:0] start;
        int               n;

        n = $urandom_range(4, 0);
        for (int i = 0; i < n; i++)
            step_sample(8, 1'(i + 1));
        start = clock_ms;
        while (clock_ms - start < hold_ms)
            step_sample(step_max, 1'b1);
        n = $urandom_range(4, 0);
        for (int i = 0; i < n; i++)
            step_sample(8, 1'(i));
        n = $urandom_range(6, 1);
        for (int i = 0; i < n; i++)
            step_sample(step_max, $urandom_range(9, 0) == 0);
    endtask

    // ------------------------------------------------------------------
    // result side: ready pattern set on the falling edge
    // ------------------------------------------------------------------
    initial begin : result_ready
        bit held_off;
        bit free_run;
        int mode_left;
        int r;

        held_off  = 1'b0;
        free_run  = 1'b0;
        mode_left = 0;
        forever begin
            @(negedge clk);
            if (!held_off && board.results_seen >= 100) begin
                // long back-pressure: both stages fill and the sample side stalls
                held_off = 1'b1;
                m_tready <= 1'b0;
                repeat (80) @(negedge clk);
            end else begin
                if (mode_left == 0) begin
                    free_run  = ($urandom_range(3, 0) == 0);
                    mode_left = 50;
                end
                mode_left--;
                r = $urandom_range(99, 0);
                if (free_run || r < 65) begin
                    m_tready <= 1'b1;
                end else if (r < 95) begin
                    m_tready <= 1'b0;
                end else begin
                    m_tready <= 1'b0;
                    repeat ($urandom_range(25, 5)) @(negedge clk);
                end
            end
        end
    end

    // result transfers checked on the rising edge
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready)
            board.check_status(m_tdata);
    end

    // watchdog: any transfer clears the count
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet >= IdleLimit) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        int guard;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // boot on a GPIO wake with a 500 ms window; long press off for now
        write_reg(REG_HOLD_TO_SLEEP, 16'd0);
        write_reg(REG_WAKE_WINDOW, 16'd500);
        write_reg(REG_BOOT_CAUSE, 16'(CAUSE_GPIO_WAKE));

        // directed: window opens just before the time stamp wraps
        send_sample(32'hFFFF_FF00, 1'b0, 1'b1);   // first sample never times out
        send_sample(32'h0000_0010, 1'b0, 1'b1);   // wrapped, still inside window
        send_sample(32'h0000_00F3, 1'b0, 1'b0);   // one short of the window
        send_sample(32'h0000_0100, 1'b1, 1'b0);   // press accepts the boot
        send_sample(32'h0000_0200, 1'b1, 1'b1);   // still held from boot
        send_sample(32'h0000_0300, 1'b0, 1'b1);   // released: monitor, state cleared
        send_sample(32'h0000_0310, 1'b1, 1'b0);   // debounced rises
        send_sample(32'h0000_0320, 1'b0, 1'b0);   // bounce inside debounce, ignored
        send_sample(32'h0000_032E, 1'b0, 1'b1);   // exactly debounce later: falls
        send_sample(32'h0000_032E, 1'b1, 1'b1);   // same stamp, no change
        send_sample(32'hFFFF_FFFF, 1'b1, 1'b0);   // far jump, rises
        send_sample(32'h0000_0005, 1'b1, 1'b1);   // wrap while held
        send_sample(32'h0000_001D, 1'b0, 1'b0);   // debounce met across the wrap
        send_sample(32'h0001_0000, 1'b1, 1'b1);
        send_sample(32'h8000_0000, 1'b1, 1'b0);   // huge hold, trigger disabled
        send_sample(32'h0000_0000, 1'b0, 1'b0);

        // random phase with no debounce: arbitrary stamps, some back-to-back stretch
        drain();
        write_reg(REG_DEBOUNCE, 16'd0);
        write_reg(REG_BOOT_CAUSE, 16'(CAUSE_OTHER_RESET));
        gaps_off = 1'b1;
        while (board.samples_seen < 196) begin
            if (board.samples_seen >= 56)
                gaps_off = 1'b0;
            if ($urandom_range(4, 0) == 0)
                send_sample($urandom, 1'($urandom), 1'($urandom));
            else
                step_sample(63, 1'($urandom));
        end

        // longest debounce and hold; presses stay far below the hold time
        drain();
        write_reg(REG_DEBOUNCE, 16'd255);
        write_reg(REG_HOLD_TO_SLEEP, 16'hFFFF);
        write_reg(REG_WAKE_WINDOW, 16'hFFFF);
        write_reg(REG_BOOT_CAUSE, 16'(CAUSE_OTHER_WAKE));
        while (board.samples_seen < 346)
            press_sequence($urandom_range(900, 10), 60);

        // typical settings; presses kept under the 3 s hold
        drain();
        write_reg(REG_HOLD_TO_SLEEP, 16'd3000);
        write_reg(REG_DEBOUNCE, 16'd30);
        write_reg(REG_WAKE_WINDOW, 16'd0);
        write_reg(REG_BOOT_CAUSE, 16'(CAUSE_POWER_ON));
        while (board.samples_seen < 496)
            press_sequence(($urandom_range(9, 0) == 0) ? 2000 : $urandom_range(600, 20), 40);

        // long press to sleep: hold until the sleep sequence starts, keep holding, release
        drain();
        write_reg(REG_HOLD_TO_SLEEP, 16'd1500);
        guard = 0;
        while (board.ctl.phase != PH_SLEEP_WAIT && guard < 300) begin
            step_sample(40, 1'b1);
            guard++;
        end
        repeat (3) step_sample(40, 1'b1);
        step_sample(40, 1'b0);
        // asleep: everything below is ignored by the block
        repeat (8) send_sample($urandom, 1'($urandom), 1'($urandom));

        drain();
        repeat (8) @(posedge clk);
        $display("covered %0d samples, %0d register writes, %0d results checked",
                 board.samples_seen, reg_writes, board.results_seen);
        $display("boot verify, wrap-around debounce at 0/30/255 ms, long-press sleep, asleep");
        if (board.errors == 0 && board.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: power_key_long_press_controller_top.f
sv/pkc_pkg.sv
sv/pkc_cfg_regs.sv
sv/pkc_step.sv
sv/power_key_long_press_controller_top.sv
tb/pkc_status_board_pkg.sv
tb/power_key_long_press_controller_top_test.sv
